// ----- rtl/core/hll_pkg.sv -----
package hll_pkg;

    localparam int INDEX_BITS = 7;
    localparam int NUM_REGS   = 1 << INDEX_BITS;
    localparam int RANK_CAP   = 33 - INDEX_BITS;
    localparam int RANK_W     = 5;
    localparam int OUT_IDX_W  = 7;

    localparam logic [31:0] HASH_MULT = 32'd2654435761;
    localparam logic [15:0] MIN_FRAME = 16'd34;
    localparam logic [15:0] ETH_IPV4  = 16'h0800;

    localparam logic MODE_UPDATE = 1'b0;
    localparam logic MODE_READ   = 1'b1;

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 56;

    typedef logic [INDEX_BITS-1:0] t_idx;
    typedef logic [RANK_W-1:0]     t_rank;

    typedef struct packed {
        logic        mode;
        logic [15:0] frame_length;
        logic [15:0] ether_type;
        logic [31:0] src_addr;
        logic [7:0]  read_index;
    } t_item;

    typedef struct packed {
        logic  upd;
        logic  rd;
        t_idx  idx;
        t_rank rank;
    } t_req;

    typedef struct packed {
        logic                 counted;
        logic [OUT_IDX_W-1:0] reg_index;
        t_rank                rank;
        t_rank                reg_value;
        logic [31:0]          packet_count;
    } t_result;

endpackage

// ----- rtl/core/hll_front.sv -----
module hll_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_item_vld,
    output logic          o_item_rdy,
    input  hll_pkg::t_item i_item,
    output logic          o_req_vld,
    input  logic          i_req_rdy,
    output hll_pkg::t_req o_req
);

    logic           r_s1_vld;
    hll_pkg::t_item r_s1;
    logic           r_s2_vld;
    logic           r_s2_upd;
    logic           r_s2_rd;
    logic [31:0]    r_s2_hash;
    hll_pkg::t_idx  r_s2_ridx;

    logic           s1_rdy;
    logic           s2_rdy;
    logic           n_upd;
    logic           n_rd;
    logic [31:0]    n_hash;
    hll_pkg::t_rank rank;

    assign s2_rdy     = !r_s2_vld || i_req_rdy;
    assign s1_rdy     = !r_s1_vld || s2_rdy;
    assign o_item_rdy = s1_rdy;

    assign n_upd  = (r_s1.mode == hll_pkg::MODE_UPDATE)
                 && (r_s1.frame_length >= hll_pkg::MIN_FRAME)
                 && (r_s1.ether_type == hll_pkg::ETH_IPV4);
    assign n_rd   = (r_s1.mode == hll_pkg::MODE_READ)
                 && ((r_s1.read_index >> hll_pkg::INDEX_BITS) == 8'd0);
    assign n_hash = 32'(r_s1.src_addr * hll_pkg::HASH_MULT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            if (s1_rdy) begin
                r_s1_vld <= i_item_vld;
            end
            if (s2_rdy) begin
                r_s2_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_rdy && i_item_vld) begin
            r_s1 <= i_item;
        end
        if (s2_rdy && r_s1_vld) begin
            r_s2_upd  <= n_upd;
            r_s2_rd   <= n_rd;
            r_s2_hash <= n_hash;
            r_s2_ridx <= hll_pkg::t_idx'(r_s1.read_index);
        end
    end

    // trailing zeros plus one, capped
    always_comb begin
        rank = hll_pkg::t_rank'(hll_pkg::RANK_CAP);
        for (int i = hll_pkg::RANK_CAP - 2; i >= 0; i--) begin
            if (r_s2_hash[i]) begin
                rank = hll_pkg::t_rank'(i + 1);
            end
        end
    end

    always_comb begin
        o_req_vld  = r_s2_vld;
        o_req.upd  = r_s2_upd;
        o_req.rd   = r_s2_rd;
        o_req.idx  = r_s2_rd ? r_s2_ridx : r_s2_hash[31 -: hll_pkg::INDEX_BITS];
        o_req.rank = rank;
    end

endmodule

// ----- rtl/core/hll_sketch.sv -----
module hll_sketch (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_vld,
    output logic             o_req_rdy,
    input  hll_pkg::t_req    i_req,
    output logic             o_res_vld,
    input  logic             i_res_rdy,
    output hll_pkg::t_result o_res
);

    hll_pkg::t_rank mem [hll_pkg::NUM_REGS];
    logic [hll_pkg::NUM_REGS-1:0] r_valid;

    logic           r_vld;
    logic           r_upd;
    logic           r_rd;
    hll_pkg::t_idx  r_idx;
    hll_pkg::t_rank r_rank;
    hll_pkg::t_rank r_mem_q;
    logic           r_vbit;
    logic           r_fwd_hit;
    hll_pkg::t_rank r_fwd_val;
    logic [31:0]    r_count;

    logic           adv;
    logic           fire;
    logic           wr_en;
    hll_pkg::t_rank cur;
    hll_pkg::t_rank n_val;
    logic [31:0]    n_count;

    assign o_req_rdy = !r_vld || i_res_rdy;
    assign adv       = i_req_vld && o_req_rdy;
    assign fire      = r_vld && i_res_rdy;
    assign wr_en     = fire && r_upd;

    assign cur     = r_fwd_hit ? r_fwd_val : (r_vbit ? r_mem_q : '0);
    assign n_val   = (r_rank > cur) ? r_rank : cur;
    assign n_count = r_upd ? r_count + 32'd1 : r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= 1'b0;
            r_valid <= '0;
            r_count <= '0;
        end else begin
            if (o_req_rdy) begin
                r_vld <= i_req_vld;
            end
            if (wr_en) begin
                r_valid[r_idx] <= 1'b1;
            end
            if (fire) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_idx] <= n_val;
        end
        if (adv) begin
            r_mem_q   <= mem[i_req.idx];
            r_vbit    <= r_valid[i_req.idx];
            // write-back on the same edge is not yet visible in the read
            r_fwd_hit <= wr_en && (r_idx == i_req.idx);
            r_fwd_val <= n_val;
            r_upd     <= i_req.upd;
            r_rd      <= i_req.rd;
            r_idx     <= i_req.idx;
            r_rank    <= i_req.rank;
        end
    end

    always_comb begin
        o_res_vld          = r_vld;
        o_res.counted      = r_upd;
        o_res.reg_index    = (r_upd || r_rd) ? hll_pkg::OUT_IDX_W'(r_idx) : '0;
        o_res.rank         = r_upd ? r_rank : '0;
        o_res.reg_value    = r_upd ? n_val : (r_rd ? cur : '0);
        o_res.packet_count = n_count;
    end

endmodule

// ----- rtl/core/hyperloglog_register_update.sv -----
// Stages: front s1, s2, sketch, output register. Throughput: one word per
// cycle unless i_m_tready stalls; sketch memory is read per accepted request
// and written back per update, forwarding between consecutive updates.
// Reset (i_rst_n low, synchronous) zeroes all ranks via their valid bits, the
// packet count and all pipeline valids; no clearing pass is needed.
module hyperloglog_register_update (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // frame_length, ether_type, src_addr, read_index
    input  logic [hll_pkg::IN_DATA_W-1:0]      i_s_tdata,
    // mode
    input  logic                               i_s_tuser,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // reg_index, rank, reg_value, packet_count, zero pad
    output logic [hll_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    // counted
    output logic                               o_m_tuser
);

    hll_pkg::t_item   item;
    hll_pkg::t_req    req;
    hll_pkg::t_result res;
    logic             req_vld;
    logic             req_rdy;
    logic             res_vld;
    logic             res_rdy;

    logic             r_out_vld;
    hll_pkg::t_result r_out;

    always_comb begin
        item.mode         = i_s_tuser;
        item.frame_length = i_s_tdata[15:0];
        item.ether_type   = i_s_tdata[31:16];
        item.src_addr     = i_s_tdata[63:32];
        item.read_index   = i_s_tdata[71:64];
    end

    hll_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item_vld (i_s_tvalid),
        .o_item_rdy (o_s_tready),
        .i_item     (item),
        .o_req_vld  (req_vld),
        .i_req_rdy  (req_rdy),
        .o_req      (req)
    );

    hll_sketch u_sketch (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req_vld (req_vld),
        .o_req_rdy (req_rdy),
        .i_req     (req),
        .o_res_vld (res_vld),
        .i_res_rdy (res_rdy),
        .o_res     (res)
    );

    assign res_rdy = !r_out_vld || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_rdy) begin
            r_out_vld <= res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_rdy && res_vld) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tuser  = r_out.counted;
    assign o_m_tdata  = {7'd0, r_out.packet_count, r_out.reg_value, r_out.rank,
                         r_out.reg_index};

`ifndef ASSERT_OFF
    a_counted_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata[11:7] != 5'd0)
                                      && (o_m_tdata[16:12] >= o_m_tdata[11:7]))
        else $error("counted word with bad rank or register value");
    a_uncounted_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata[11:7] == 5'd0))
        else $error("uncounted word carries a rank");
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_vld && res_rdy && res.counted && !r_out_vld) |=>
            (o_m_tdata[48:17] != 32'd0 || $past(res.packet_count) == 32'd0))
        else $error("packet count not advanced");
`endif

endmodule
